>>> hdl/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg: shared types and constants of the multimode setpoint controller
// Holds the fixed-point format, the mode codes and the register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package msc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int INDEX_W   = 3;

   typedef enum logic [2:0] {
      MODE_BANG   = 3'd0,
      MODE_PROP   = 3'd1,
      MODE_THREE  = 3'd2,
      MODE_FIVE   = 3'd3,
      MODE_STATIC = 3'd4
   } mode_type;

   typedef enum logic [INDEX_W-1:0] {
      REG_MODE        = 3'd0,
      REG_TARGET      = 3'd1,
      REG_PARAM_A     = 3'd2,
      REG_PARAM_B     = 3'd3,
      REG_GAIN        = 3'd4,
      REG_LIMIT_EN    = 3'd5,
      REG_NEGATIVE_EN = 3'd6,
      REG_FALSE_BELOW = 3'd7
   } reg_index_type;

endpackage
`default_nettype wire

>>> hdl/msc_div.sv
// ----------------------------------------------------------------------------
// msc_div: pipelined unsigned restoring divider
// Produces one quotient bit per stage and accepts a new word every cycle.
// A signed tag travels alongside each word.
// ----------------------------------------------------------------------------
`default_nettype none
module msc_div #(
   parameter int DVD_W = 48,
   parameter int DVS_W = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire logic [DVD_W-1:0]        in_dividend,
   input  wire logic [DVS_W-1:0]        in_divisor,
   input  wire logic signed [DVS_W-1:0] in_tag,
   output logic                         out_valid,
   output logic [DVD_W-1:0]             out_quotient,
   output logic signed [DVS_W-1:0]      out_tag
);

   logic                    valid_ff [DVD_W];
   logic [DVS_W:0]          rem_ff   [DVD_W];
   logic [DVD_W-1:0]        quo_ff   [DVD_W];
   logic [DVD_W-1:0]        dvd_ff   [DVD_W];
   logic signed [DVS_W-1:0] tag_ff   [DVD_W];

   for (genvar k = 0; k < DVD_W; k++) begin : g_stage
      logic                    valid_prev;
      logic [DVS_W:0]          rem_prev;
      logic [DVD_W-1:0]        quo_prev;
      logic [DVD_W-1:0]        dvd_prev;
      logic signed [DVS_W-1:0] tag_prev;
      logic [DVS_W:0]          rem_shift;
      logic                    ge;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign quo_prev   = '0;
         assign dvd_prev   = in_dividend;
         assign tag_prev   = in_tag;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign quo_prev   = quo_ff[k-1];
         assign dvd_prev   = dvd_ff[k-1];
         assign tag_prev   = tag_ff[k-1];
      end

      // The remainder stays below the divisor, so its top bit is always clear.
      assign rem_shift = {rem_prev[DVS_W-1:0], dvd_prev[DVD_W-1]};
      assign ge        = rem_shift >= {1'b0, in_divisor};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= ge ? rem_shift - {1'b0, in_divisor} : rem_shift;
         quo_ff[k] <= {quo_prev[DVD_W-2:0], ge};
         dvd_ff[k] <= {dvd_prev[DVD_W-2:0], 1'b0};
         tag_ff[k] <= tag_prev;
      end
   end

   assign out_valid    = valid_ff[DVD_W-1];
   assign out_quotient = quo_ff[DVD_W-1];
   assign out_tag      = tag_ff[DVD_W-1];

endmodule
`default_nettype wire

>>> hdl/multimode_setpoint_controller.sv
// ----------------------------------------------------------------------------
// multimode_setpoint_controller: five-mode setpoint drive generator
// Turns a measured value into a gained, optionally limited drive word and an ok flag.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with req_measured for one cycle to hand in a word; busy is
//   always low, so a word is taken on every cycle that start is high.
//   Each word yields one result, shown on rsp_drive and rsp_ok for exactly one
//   cycle while rsp_valid is high. The receiver cannot stall the block.
//   A word passes through the error stage, then the divider, which resolves one
//   quotient bit per stage over 32 + FRAC_BITS stages, then the mode, multiply
//   and output stages.
//   Throughput is one word per cycle in every mode; results leave in order.
//   The user must write registers through csr_we, csr_index and csr_wdata only while
//   no word is in flight; the block does not enforce this. They take their new values at once.
//   Reset empties the pipeline and loads every register with its reset value.
// ----------------------------------------------------------------------------
`default_nettype none
module multimode_setpoint_controller #(
   parameter int FRAC_BITS = msc_pkg::FRAC_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [msc_pkg::DATA_W-1:0]   req_measured,
   input  wire logic                                csr_we,
   input  wire logic [msc_pkg::INDEX_W-1:0]         csr_index,
   input  wire logic [msc_pkg::DATA_W-1:0]          csr_wdata,
   output logic                                     rsp_valid,
   output logic signed [msc_pkg::DATA_W-1:0]        rsp_drive,
   output logic                                     rsp_ok
);

   localparam int W    = msc_pkg::DATA_W;
   localparam int DW   = W + FRAC_BITS;
   localparam int PW   = 2 * W;

   localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] ONE   = W'(64'd1 << FRAC_BITS);
   localparam logic signed [W-1:0] HALF  = W'(64'd1 << (FRAC_BITS - 1));
   localparam logic [DW-1:0] Q_POS_MAX = {{(DW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [DW-1:0] Q_NEG_MAX = {{(DW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

   // Configuration registers.
   msc_pkg::mode_type mode_ff;
   logic signed [W-1:0] target_ff, param_a_ff, param_b_ff, gain_ff, false_below_ff;
   logic limit_en_ff, negative_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= msc_pkg::MODE_BANG;
         target_ff      <= '0;
         param_a_ff     <= W'(32768);
         param_b_ff     <= W'(43254);
         gain_ff        <= W'(65536);
         limit_en_ff    <= 1'b1;
         negative_en_ff <= 1'b1;
         false_below_ff <= -W'(65536);
      end else if (csr_we) begin
         case (msc_pkg::reg_index_type'(csr_index))
            msc_pkg::REG_MODE:        mode_ff <= msc_pkg::mode_type'(csr_wdata[2:0]);
            msc_pkg::REG_TARGET:      target_ff <= csr_wdata;
            msc_pkg::REG_PARAM_A:     param_a_ff <= csr_wdata;
            msc_pkg::REG_PARAM_B:     param_b_ff <= csr_wdata;
            msc_pkg::REG_GAIN:        gain_ff <= csr_wdata;
            msc_pkg::REG_LIMIT_EN:    limit_en_ff <= csr_wdata[0];
            msc_pkg::REG_NEGATIVE_EN: negative_en_ff <= csr_wdata[0];
            msc_pkg::REG_FALSE_BELOW: false_below_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // Stage 1: saturated error.
   logic                 s1_valid_ff;
   logic signed [W-1:0]  s1_err_ff;
   logic signed [W:0]    diff;
   logic signed [W-1:0]  err_in;

   always_comb begin
      diff = {req_measured[W-1], req_measured} - {target_ff[W-1], target_ff};
      if (diff[W] != diff[W-1]) begin
         err_in = diff[W] ? S_MIN : S_MAX;
      end else begin
         err_in = diff[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      s1_err_ff <= err_in;
   end

   // Divider on magnitudes; the error rides along as the tag.
   logic [W-1:0]         err_mag;
   logic [W-1:0]         a_mag;
   logic                 dv_valid;
   logic [DW-1:0]        dv_quo;
   logic signed [W-1:0]  dv_err;

   assign err_mag = s1_err_ff[W-1] ? W'(-s1_err_ff) : W'(s1_err_ff);
   assign a_mag   = param_a_ff[W-1] ? W'(-param_a_ff) : W'(param_a_ff);

   msc_div #(
      .DVD_W(DW),
      .DVS_W(W)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s1_valid_ff),
      .in_dividend ({err_mag, {FRAC_BITS{1'b0}}}),
      .in_divisor  (a_mag),
      .in_tag      (s1_err_ff),
      .out_valid   (dv_valid),
      .out_quotient(dv_quo),
      .out_tag     (dv_err)
   );

   // Stage 2: drive by mode.
   logic                 s2_valid_ff;
   logic signed [W-1:0]  s2_drive_ff;
   logic signed [W-1:0]  drive_in;
   logic signed [W-1:0]  sign_val;
   logic signed [W:0]    mag_s;
   logic                 below_a, below_b, q_neg;
   logic signed [W-1:0]  five;

   always_comb begin
      mag_s    = dv_err[W-1] ? -{dv_err[W-1], dv_err} : {dv_err[W-1], dv_err};
      below_a  = mag_s < $signed({param_a_ff[W-1], param_a_ff});
      below_b  = mag_s < $signed({param_b_ff[W-1], param_b_ff});
      sign_val = (dv_err == '0) ? '0 : (dv_err[W-1] ? -ONE : ONE);
      q_neg    = dv_err[W-1] ^ param_a_ff[W-1];
      five     = below_a ? '0 : (below_b ? HALF : ONE);
      case (mode_ff)
         msc_pkg::MODE_BANG: drive_in = sign_val;
         msc_pkg::MODE_PROP: begin
            if (param_a_ff == '0) begin
               drive_in = (dv_err == '0) ? '0 : (dv_err[W-1] ? S_MIN : S_MAX);
            end else if (!q_neg) begin
               drive_in = (dv_quo > Q_POS_MAX) ? S_MAX : dv_quo[W-1:0];
            end else begin
               drive_in = (dv_quo > Q_NEG_MAX) ? S_MIN : W'(-dv_quo[W-1:0]);
            end
         end
         msc_pkg::MODE_THREE:  drive_in = below_a ? '0 : sign_val;
         msc_pkg::MODE_FIVE:   drive_in = dv_err[W-1] ? -five : five;
         msc_pkg::MODE_STATIC: drive_in = param_a_ff;
         default:              drive_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      s2_drive_ff <= drive_in;
   end

   // Stage 3: gain product.
   logic                 s3_valid_ff;
   logic signed [PW-1:0] s3_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_prod_ff <= s2_drive_ff * gain_ff;
   end

   // Stage 4: scale, saturate, limit, map and flag.
   logic signed [PW-1:0] shifted;
   logic signed [W-1:0]  gained, limited, mapped;
   logic signed [W:0]    plus_one, abs_d;
   logic                 ok_in;
   logic                 rsp_valid_ff, rsp_ok_ff;
   logic signed [W-1:0]  rsp_drive_ff;

   always_comb begin
      shifted = s3_prod_ff >>> FRAC_BITS;
      if (shifted > PW'(S_MAX)) begin
         gained = S_MAX;
      end else if (shifted < PW'(S_MIN)) begin
         gained = S_MIN;
      end else begin
         gained = shifted[W-1:0];
      end
      limited = gained;
      if (limit_en_ff) begin
         if (gained < -ONE) begin
            limited = -ONE;
         end else if (gained > ONE) begin
            limited = ONE;
         end
      end
      plus_one = {limited[W-1], limited} + {ONE[W-1], ONE};
      mapped   = negative_en_ff ? limited : plus_one[W:1];
      abs_d    = mapped[W-1] ? -{mapped[W-1], mapped} : {mapped[W-1], mapped};
      ok_in    = !(abs_d < $signed({false_below_ff[W-1], false_below_ff}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_drive_ff <= mapped;
      rsp_ok_ff    <= ok_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;
   assign rsp_ok    = rsp_ok_ff;

endmodule
`default_nettype wire

>>> bench/multimode_setpoint_controller_tb.sv
// ----------------------------------------------------------------------------
// multimode_setpoint_controller_tb: self-checking bench for the drive generator
// Feeds measured words in several register settings, predicts each drive word
// and ok flag, and compares them in order with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module multimode_setpoint_controller_tb;

   localparam int     LATENCY = 36 + msc_pkg::FRAC_BITS;
   localparam longint ONE     = longint'(1) << msc_pkg::FRAC_BITS;
   localparam longint HALF    = longint'(1) << (msc_pkg::FRAC_BITS - 1);
   localparam longint SMAX    = 64'sd2147483647;
   localparam longint SMIN    = -64'sd2147483648;

   typedef struct packed {
      logic signed [msc_pkg::DATA_W-1:0] drive;
      logic                              ok;
   } drive_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [msc_pkg::DATA_W-1:0] req_measured = '0;
   logic csr_we = 1'b0;
   logic [msc_pkg::INDEX_W-1:0] csr_index = '0;
   logic [msc_pkg::DATA_W-1:0] csr_wdata = '0;
   logic rsp_valid;
   logic signed [msc_pkg::DATA_W-1:0] rsp_drive;
   logic rsp_ok;

   multimode_setpoint_controller dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_measured(req_measured), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .rsp_valid(rsp_valid), .rsp_drive(rsp_drive),
      .rsp_ok(rsp_ok)
   );

   // Bench copy of the register file.
   logic [2:0] cur_mode;
   longint cur_target, cur_a, cur_b, cur_gain, cur_below;
   logic cur_limit, cur_neg;

   logic signed [msc_pkg::DATA_W-1:0] measured_queue[$];
   drive_word_type expected_drives[$];
   int error_count = 0;
   int idle_pct = 0;
   int sent_count = 0;

   initial forever #2 clock = ~clock;

   initial begin
      #1000000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic longint sat(longint v);
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
   endfunction

   function automatic longint floor_div(longint v, int sh);
      return v >>> sh;
   endfunction

   function automatic longint sign_of(longint s);
      return (s == 0) ? 0 : ((s < 0) ? -ONE : ONE);
   endfunction

   function automatic drive_word_type predict_drive(logic signed [msc_pkg::DATA_W-1:0] meas);
      longint s, mag, d;
      drive_word_type w;
      s = sat(longint'(meas) - cur_target);
      mag = (s < 0) ? -s : s;
      case (cur_mode)
         msc_pkg::MODE_BANG: d = sign_of(s);
         msc_pkg::MODE_PROP: begin
            if (cur_a == 0) d = (s == 0) ? 0 : ((s < 0) ? SMIN : SMAX);
            else d = sat((s * ONE) / cur_a);
         end
         msc_pkg::MODE_THREE: d = (mag < cur_a) ? 0 : sign_of(s);
         msc_pkg::MODE_FIVE: begin
            d = (mag < cur_a) ? 0 : ((mag < cur_b) ? HALF : ONE);
            if (s < 0) d = -d;
         end
         msc_pkg::MODE_STATIC: d = cur_a;
         default: d = 0;
      endcase
      d = sat(floor_div(d * cur_gain, msc_pkg::FRAC_BITS));
      if (cur_limit) begin
         if (d < -ONE) d = -ONE;
         else if (d > ONE) d = ONE;
      end
      if (!cur_neg) d = floor_div(d + ONE, 1);
      w.drive = d[31:0];
      w.ok = (((d < 0) ? -d : d) < cur_below) ? 1'b0 : 1'b1;
      return w;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Driver: one word per cycle at most, with random gaps.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         expected_drives.push_back(predict_drive(req_measured));
         sent_count++;
      end
      if (measured_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
         start <= 1'b1;
         req_measured <= measured_queue.pop_front();
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_drives.size() == 0) begin
            report_mismatch("unexpected word", rsp_drive, 0);
         end else begin
            drive_word_type w;
            w = expected_drives.pop_front();
            if (rsp_drive !== w.drive) report_mismatch("drive", rsp_drive, w.drive);
            if (rsp_ok !== w.ok) report_mismatch("ok", rsp_ok, w.ok);
         end
      end
   end

   task automatic write_reg(msc_pkg::reg_index_type idx, longint value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[31:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         msc_pkg::REG_MODE:        cur_mode = value[2:0];
         msc_pkg::REG_TARGET:      cur_target = longint'($signed(value[31:0]));
         msc_pkg::REG_PARAM_A:     cur_a = longint'($signed(value[31:0]));
         msc_pkg::REG_PARAM_B:     cur_b = longint'($signed(value[31:0]));
         msc_pkg::REG_GAIN:        cur_gain = longint'($signed(value[31:0]));
         msc_pkg::REG_LIMIT_EN:    cur_limit = value[0];
         msc_pkg::REG_NEGATIVE_EN: cur_neg = value[0];
         default:                  cur_below = longint'($signed(value[31:0]));
      endcase
   endtask

   // Waits until every word handed in has come back, then lets the pipe drain.
   task automatic drain();
      while (measured_queue.size() > 0 || start) @(posedge clock);
      @(posedge clock);
      while (expected_drives.size() > 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_fixed();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'(longint'($urandom_range(32'(2 * ONE))) - ONE);
         2: return 32'(longint'($urandom_range(32'(16 * ONE))) - 8 * ONE);
         default: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      endcase
   endfunction

   task automatic random_phase(int count);
      repeat (count) begin
         measured_queue.push_back(rand_fixed() + cur_target[31:0]);
      end
      drain();
   endtask

   task automatic random_setting(logic [2:0] m);
      write_reg(msc_pkg::REG_MODE, m);
      write_reg(msc_pkg::REG_TARGET, $urandom_range(3) == 0 ? rand_fixed()
                                     : $urandom_range(4 * ONE) - 2 * ONE);
      write_reg(msc_pkg::REG_PARAM_A, $urandom_range(7) == 0 ? 0
                                      : ($urandom_range(1) ? rand_fixed()
                                         : $urandom_range(2 * ONE)));
      write_reg(msc_pkg::REG_PARAM_B, $urandom_range(1) ? rand_fixed()
                                      : $urandom_range(3 * ONE));
      write_reg(msc_pkg::REG_GAIN, $urandom_range(2) == 0 ? rand_fixed()
                                   : $urandom_range(4 * ONE) - 2 * ONE);
      write_reg(msc_pkg::REG_LIMIT_EN, $urandom_range(1));
      write_reg(msc_pkg::REG_NEGATIVE_EN, $urandom_range(1));
      write_reg(msc_pkg::REG_FALSE_BELOW, $urandom_range(1) ? rand_fixed()
                                          : $urandom_range(ONE));
   endtask

   initial begin
      longint edges[] = '{SMIN, SMAX, 0, 1, -1, ONE, -ONE, HALF, -HALF, 43254, -43254};
      cur_mode = msc_pkg::MODE_BANG; cur_target = 0; cur_a = 32768; cur_b = 43254;
      cur_gain = 65536; cur_limit = 1'b1; cur_neg = 1'b1; cur_below = -65536;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed part: field extremes and band edges at reset settings, then each mode.
      foreach (edges[i]) measured_queue.push_back(edges[i][31:0]);
      drain();
      for (int m = 0; m < 8; m++) begin
         write_reg(msc_pkg::REG_MODE, m);
         if (m == 1) write_reg(msc_pkg::REG_PARAM_A, 0);
         measured_queue.push_back(32'h8000_0000);
         measured_queue.push_back(32'h7fff_ffff);
         measured_queue.push_back(32'd0);
         drain();
         if (m == 1) write_reg(msc_pkg::REG_PARAM_A, 32768);
      end
      // Overflowing error and gain saturation with limiting off and mapping on.
      write_reg(msc_pkg::REG_MODE, msc_pkg::MODE_PROP);
      write_reg(msc_pkg::REG_TARGET, 32'h8000_0000);
      write_reg(msc_pkg::REG_PARAM_A, 1);
      write_reg(msc_pkg::REG_GAIN, 32'h7fff_ffff);
      write_reg(msc_pkg::REG_LIMIT_EN, 0);
      write_reg(msc_pkg::REG_NEGATIVE_EN, 0);
      write_reg(msc_pkg::REG_FALSE_BELOW, 32'h7fff_ffff);
      measured_queue.push_back(32'h7fff_ffff);
      measured_queue.push_back(32'h8000_0000);
      drain();
      write_reg(msc_pkg::REG_TARGET, 32'h7fff_ffff);
      write_reg(msc_pkg::REG_GAIN, 32'h8000_0000);
      write_reg(msc_pkg::REG_PARAM_A, 32'h8000_0000);
      measured_queue.push_back(32'h8000_0000);
      measured_queue.push_back(32'h7fff_ffff);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 27 : ((phase == 1) ? 79 : 0);
         for (int k = 0; k < 10; k++) begin
            random_setting((k % 6 == 5) ? 3'($urandom_range(7)) : 3'(k % 5));
            random_phase(20);
         end
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
